[hw/rtl/dtq_pkg.sv]
package dtq_pkg;

	// default sizing
	localparam int DEF_NUM_TASKS = 32;
	localparam int DEF_TIME_BITS = 32;

	// fixed field widths
	localparam int TASK_W      = 5;
	localparam int TIMEOUT_W   = 32;
	localparam int POS_W       = 6;
	localparam int DELTA_W     = 32;

	// stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// input field placement
	localparam int IN_TASK_LSB    = 0;
	localparam int IN_TIMEOUT_LSB = TASK_W;

	// output field placement
	localparam int OUT_HEAD_BIT  = 0;
	localparam int OUT_POS_LSB   = 1;
	localparam int OUT_DELTA_LSB = OUT_POS_LSB + POS_W;
	localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_DELTA_LSB - DELTA_W;

endpackage

[hw/rtl/delta_timeout_queue_insert_top.sv]
// Channel  Dir  Fields (tdata, lowest bit first)
// s_*      in   task_req[4:0], timeout[36:5], zero pad [39:37]
// m_*      out  became_head[0], position[6:1], stored_delta[38:7], zero pad [39]
//
// Accept to result load: a walk goes through S_FIRST, S_CMP for each entry, S_LINK1,
// S_LINK2 and S_DONE; an out-of-range task number or an empty queue goes straight to
// S_DONE. The next accept waits for the return to S_IDLE after the result loads.
// One shared subtractor does a compare and subtract per entry, fed by registered reads.
// s_tready is high only while idle. Reset empties the queue; memories need no clearing.
// A stalled result waits in the output register while the next item is taken and walked.
module delta_timeout_queue_insert_top #(
	parameter int NUM_TASKS = dtq_pkg::DEF_NUM_TASKS,
	parameter int TIME_BITS = dtq_pkg::DEF_TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// task_req[4:0], timeout[36:5], zero pad
	input  logic [dtq_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// became_head[0], position[6:1], stored_delta[38:7], zero pad
	output logic [dtq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	import dtq_pkg::*;

	localparam int IW = $clog2(NUM_TASKS);
	localparam int PW = $clog2(NUM_TASKS + 1);
	localparam int TW = TIME_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_CMP,
		S_LINK1,
		S_LINK2,
		S_DONE
	} state_t;

	state_t         state_q;
	logic           empty_q;
	logic [IW-1:0]  head_q;
	logic [IW-1:0]  task_q;
	logic [IW-1:0]  nx_q;
	logic [IW-1:0]  pv_q;
	logic [PW-1:0]  pos_q;
	logic [TW-1:0]  t_q;
	logic [TW-1:0]  d_stop_q;
	logic           stop_q;
	logic           at_head_q;
	logic           res_head_q;
	logic           m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// memory ports
	logic           next_we, prev_we, delta_we;
	logic [IW-1:0]  next_wa, prev_wa, delta_wa;
	logic [IW-1:0]  next_wd, prev_wd;
	logic [TW-1:0]  delta_wd;
	logic           rd_en, prev_re;
	logic [IW-1:0]  rd_addr;
	logic [IW-1:0]  next_rd, prev_rd;
	logic [TW-1:0]  delta_rd;

	// input decode
	logic           in_acc;
	logic [IW+TASK_W-1:0]    task_ext;
	logic [IW-1:0]           task_in;
	logic                    task_ok;
	logic [TW+TIMEOUT_W-1:0] tin_ext;
	logic [TW-1:0]           t_in;

	// shared subtractor
	logic [TW-1:0]  sub_a, sub_b;
	logic [TW:0]    sub_y;
	logic           t_lt_d;

	// walk helpers
	logic [IW-1:0]  pv_cur;
	logic [PW-1:0]  pos_inc;
	logic           walk_end;

	// output packing
	logic [PW+POS_W-1:0]  pos_ext;
	logic [TW+DELTA_W-1:0] dl_ext;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign task_ext = {{IW{1'b0}}, s_tdata[IN_TASK_LSB +: TASK_W]};
	assign task_in  = task_ext[IW-1:0];
	assign task_ok  = task_ext < (IW+TASK_W)'(NUM_TASKS);
	assign tin_ext  = {{TW{1'b0}}, s_tdata[IN_TIMEOUT_LSB +: TIMEOUT_W]};
	assign t_in     = tin_ext[TW-1:0];

	// subtractor: remainder minus delta while walking, delta minus remainder at link
	assign sub_a  = (state_q == S_LINK1) ? d_stop_q : t_q;
	assign sub_b  = (state_q == S_LINK1) ? t_q : delta_rd;
	assign sub_y  = {1'b0, sub_a} - {1'b0, sub_b};
	assign t_lt_d = sub_y[TW];

	assign pv_cur   = (pos_q == '0) ? prev_rd : pv_q;
	assign pos_inc  = pos_q + PW'(1);
	assign walk_end = (next_rd == head_q) || (pos_inc == PW'(NUM_TASKS));

	// read the head first, then follow next links
	assign rd_en   = (state_q == S_FIRST) || (state_q == S_CMP);
	assign prev_re = (state_q == S_FIRST);
	assign rd_addr = (state_q == S_FIRST) ? head_q : next_rd;

	// memory write selection
	always_comb begin
		next_we  = 1'b0;
		prev_we  = 1'b0;
		delta_we = 1'b0;
		next_wa  = task_q;
		prev_wa  = task_q;
		delta_wa = task_q;
		next_wd  = nx_q;
		prev_wd  = pv_q;
		delta_wd = t_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && task_ok && empty_q) begin
					next_we  = 1'b1;
					prev_we  = 1'b1;
					delta_we = 1'b1;
					next_wa  = task_in;
					prev_wa  = task_in;
					delta_wa = task_in;
					next_wd  = task_in;
					prev_wd  = task_in;
					delta_wd = t_in;
				end
			end
			S_LINK1: begin
				next_we  = 1'b1;
				prev_we  = 1'b1;
				delta_we = stop_q;
				delta_wa = nx_q;
				delta_wd = sub_y[TW-1:0];
			end
			S_LINK2: begin
				next_we  = 1'b1;
				prev_we  = 1'b1;
				delta_we = 1'b1;
				next_wa  = pv_q;
				next_wd  = task_q;
				prev_wa  = nx_q;
				prev_wd  = task_q;
			end
			default: begin
			end
		endcase
	end

	dtq_ram #(.DEPTH(NUM_TASKS), .WIDTH(IW)) u_next (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_wa),
		.wdata (next_wd),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	dtq_ram #(.DEPTH(NUM_TASKS), .WIDTH(IW)) u_prev (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_wa),
		.wdata (prev_wd),
		.re    (prev_re),
		.raddr (rd_addr),
		.rdata (prev_rd)
	);

	dtq_ram #(.DEPTH(NUM_TASKS), .WIDTH(TW)) u_delta (
		.clk   (clk),
		.we    (delta_we),
		.waddr (delta_wa),
		.wdata (delta_wd),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (delta_rd)
	);

	assign pos_ext = {{POS_W{1'b0}}, pos_q};
	assign dl_ext  = {{DELTA_W{1'b0}}, t_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			empty_q    <= 1'b1;
			head_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result valid: set when the done step loads, cleared when taken
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						task_q <= task_in;
						pos_q  <= '0;
						nx_q   <= head_q;
						if (!task_ok) begin
							res_head_q <= 1'b0;
							t_q        <= '0;
							state_q    <= S_DONE;
						end else if (empty_q) begin
							res_head_q <= 1'b1;
							t_q        <= t_in;
							head_q     <= task_in;
							empty_q    <= 1'b0;
							state_q    <= S_DONE;
						end else begin
							t_q     <= t_in;
							state_q <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (t_lt_d) begin
						stop_q    <= 1'b1;
						at_head_q <= (nx_q == head_q);
						d_stop_q  <= delta_rd;
						pv_q      <= pv_cur;
						state_q   <= S_LINK1;
					end else begin
						t_q   <= sub_y[TW-1:0];
						pv_q  <= nx_q;
						nx_q  <= next_rd;
						pos_q <= pos_inc;
						if (walk_end) begin
							stop_q    <= 1'b0;
							at_head_q <= 1'b0;
							state_q   <= S_LINK1;
						end
					end
				end
				S_LINK1: begin
					if (stop_q && at_head_q) begin
						head_q <= task_q;
					end
					state_q <= S_LINK2;
				end
				S_LINK2: begin
					res_head_q <= stop_q && at_head_q;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, dl_ext[DELTA_W-1:0], pos_ext[POS_W-1:0],
				res_head_q};
		end
	end

	// walk never counts past the queue size
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (pos_q < PW'(NUM_TASKS)))
		else $error("walk position ran past queue size");

	// linking always follows the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK1) |-> ($past(state_q) == S_CMP))
		else $error("link step entered without a walk");

	// a new result appears only from the done step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside done step");

	// head moves only while linking in front of it or on an empty insert
	assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != $past(head_q)) |->
			($past(state_q) == S_LINK1 || ($past(state_q) == S_IDLE && $past(empty_q))))
		else $error("head changed unexpectedly");

endmodule

[hw/rtl/dtq_ram.sv]
module dtq_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// one registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[test/delta_timeout_queue_insert_top_tb.sv]
`timescale 1ns / 1ps

module delta_timeout_queue_insert_top_tb;
	import dtq_pkg::*;

	localparam int NUM_TASKS  = DEF_NUM_TASKS;
	localparam int TIME_BITS  = DEF_TIME_BITS;
	localparam int ITEM_COUNT = 1450;
	// last items run with no idling on either side
	localparam int TAIL_ITEMS = 120;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [TASK_W-1:0]    task_id;
		logic [TIMEOUT_W-1:0] ticks;
	} insert_req_t;

	typedef struct packed {
		logic               became_head;
		logic [POS_W-1:0]   position;
		logic [DELTA_W-1:0] stored_delta;
	} placement_t;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	insert_req_t pending_inserts[$];
	placement_t  expected_placements[$];
	int          accepted_count = 0;
	int          total_items    = ITEM_COUNT;
	int          error_count    = 0;
	int          src_gap        = 0;
	int          sink_stall     = 0;

	// shadow of the delta list
	bit                   list_empty = 1'b1;
	int unsigned          head_id    = 0;
	int unsigned          next_of [NUM_TASKS];
	int unsigned          prev_of [NUM_TASKS];
	logic [TIME_BITS-1:0] delta_of[NUM_TASKS];
	bit                   queued  [NUM_TASKS];

	delta_timeout_queue_insert_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// link pointers that leave the table fall back to task 0
	function automatic int unsigned clip(int unsigned idx);
		return (idx < NUM_TASKS) ? idx : 0;
	endfunction

	function automatic void link_task(int unsigned id, int unsigned pv, int unsigned nx);
		next_of[id] = nx;
		prev_of[id] = pv;
		next_of[pv] = id;
		prev_of[nx] = id;
	endfunction

	// insert one task into the shadow list and return where it landed
	function automatic placement_t place_task(insert_req_t req);
		int unsigned          id;
		int unsigned          hd;
		int unsigned          nx;
		int unsigned          pv;
		int unsigned          pos;
		logic [TIME_BITS-1:0] rem;
		logic [TIME_BITS-1:0] d;
		placement_t           res;
		id  = req.task_id;
		rem = TIME_BITS'(req.ticks);
		res = '0;
		if (id >= NUM_TASKS)
			return res;
		if (list_empty) begin
			next_of[id]  = id;
			prev_of[id]  = id;
			delta_of[id] = rem;
			head_id      = id;
			list_empty   = 1'b0;
			res.became_head  = 1'b1;
			res.stored_delta = DELTA_W'(rem);
			return res;
		end
		hd  = clip(head_id);
		nx  = hd;
		pv  = clip(prev_of[hd]);
		pos = 0;
		while (pos < NUM_TASKS) begin
			d = delta_of[nx];
			if (rem < d) begin
				res.became_head = (nx == hd);
				if (nx == hd)
					head_id = id;
				delta_of[nx] = d - rem;
				delta_of[id] = rem;
				link_task(id, pv, nx);
				res.position     = POS_W'(pos);
				res.stored_delta = DELTA_W'(rem);
				return res;
			end
			// equal delta does not stop the walk
			rem = rem - d;
			pv  = nx;
			nx  = clip(next_of[nx]);
			pos++;
			if (nx == hd)
				break;
		end
		// append after the last entry visited
		delta_of[id] = rem;
		link_task(id, pv, nx);
		res.position     = POS_W'(pos);
		res.stored_delta = DELTA_W'(rem);
		return res;
	endfunction

	function automatic logic [TIMEOUT_W-1:0] random_ticks();
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom_range(0, 15);
			3, 4:    return $urandom_range(0, 4095);
			5, 6:    return $urandom;
			7:       return '0;
			8:       return '1;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic bit idle_allowed();
		return (accepted_count < total_items - TAIL_ITEMS) &&
			((accepted_count / 100) % 3 != 2);
	endfunction

	task automatic add_insert(int unsigned id, logic [TIMEOUT_W-1:0] ticks);
		insert_req_t req;
		req.task_id = TASK_W'(id);
		req.ticks   = ticks;
		pending_inserts.push_back(req);
		queued[id] = 1'b1;
	endtask

	// source side: feed pending items, with random gaps
	always @(posedge clk or negedge arst_n) begin
		insert_req_t           req;
		logic [IN_TDATA_W-1:0] word;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				s_tvalid <= 1'b0;
				src_gap  <= src_gap - 1;
			end else if (pending_inserts.size() != 0) begin
				req  = pending_inserts.pop_front();
				word = '0;
				word[IN_TASK_LSB +: TASK_W]       = req.task_id;
				word[IN_TIMEOUT_LSB +: TIMEOUT_W] = req.ticks;
				s_tdata  <= word;
				s_tvalid <= 1'b1;
				if (idle_allowed() && $urandom_range(0, 3) == 0)
					src_gap <= $urandom_range(1, 7);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side: random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			sink_stall <= 0;
		end else if (sink_stall != 0) begin
			m_tready   <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			sink_stall <= $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// predict on accept, compare on result
	always @(posedge clk) begin
		insert_req_t req;
		placement_t  exp_p;
		placement_t  got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				req.task_id = s_tdata[IN_TASK_LSB +: TASK_W];
				req.ticks   = s_tdata[IN_TIMEOUT_LSB +: TIMEOUT_W];
				expected_placements.push_back(place_task(req));
				accepted_count <= accepted_count + 1;
			end
			if (m_tvalid && m_tready) begin
				got.became_head  = m_tdata[OUT_HEAD_BIT];
				got.position     = m_tdata[OUT_POS_LSB +: POS_W];
				got.stored_delta = m_tdata[OUT_DELTA_LSB +: DELTA_W];
				if (expected_placements.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual %h",
							$time, got);
				end else begin
					exp_p = expected_placements.pop_front();
					if (got.became_head !== exp_p.became_head) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("%0t: became_head expected %0d actual %0d",
								$time, exp_p.became_head, got.became_head);
					end
					if (got.position !== exp_p.position) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("%0t: position expected %0d actual %0d",
								$time, exp_p.position, got.position);
					end
					if (got.stored_delta !== exp_p.stored_delta) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("%0t: stored_delta expected %h actual %h",
								$time, exp_p.stored_delta, got.stored_delta);
					end
				end
			end
		end
	end

	initial begin
		int unsigned spare[$];
		int unsigned pick;
		for (int i = 0; i < NUM_TASKS; i++) begin
			next_of[i]  = 0;
			prev_of[i]  = 0;
			delta_of[i] = '0;
			queued[i]   = 1'b0;
		end

		// directed: empty list, ties, new head, zero, full range, tail ties
		add_insert(5, 100);
		add_insert(9, 100);
		add_insert(2, 40);
		add_insert(0, 0);
		add_insert(31, 32'hFFFF_FFFF);
		add_insert(17, 40);
		add_insert(12, 50);
		add_insert(20, 100);
		add_insert(7, 1);
		add_insert(30, 32'hFFFF_FFFF);
		add_insert(1, 32'h8000_0000);
		add_insert(16, 32'h7FFF_FFFF);
		add_insert(3, 0);
		add_insert(24, 32'hAAAA_AAAA);
		add_insert(11, 32'h5555_5555);

		// fill the list with the remaining tasks in random order
		for (int i = 0; i < NUM_TASKS; i++)
			if (!queued[i])
				spare.push_back(i);
		while (spare.size() != 0) begin
			pick = $urandom_range(0, spare.size() - 1);
			add_insert(spare[pick], random_ticks());
			spare.delete(pick);
		end

		// list is full: every further item re-inserts a queued task
		while (pending_inserts.size() < ITEM_COUNT)
			add_insert($urandom_range(0, NUM_TASKS - 1), random_ticks());
		total_items = pending_inserts.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_items || expected_placements.size() != 0)
			@(negedge clk);
		repeat (NUM_TASKS + 10) @(posedge clk);

		if (error_count == 0 && expected_placements.size() == 0) begin
			$display("PASS delta_timeout_queue_insert_top");
		end else begin
			$display("FAIL delta_timeout_queue_insert_top");
		end
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAIL delta_timeout_queue_insert_top");
		$finish;
	end

endmodule
